/* rtl/rsch_pkg.sv */
package rsch_pkg;

   localparam int MAX_ENTRIES = 64;
   localparam int IDX_W = $clog2(MAX_ENTRIES);
   localparam int CNT_W = IDX_W + 1;
   localparam int KEY_W = 32;
   localparam int TIME_W = 32;
   localparam int PERIOD_W = 17;
   localparam int ATT_W = 3;
   localparam int ALU_W = TIME_W + 2;

   typedef logic [IDX_W-1:0] slot_type;
   typedef logic [CNT_W-1:0] count_type;
   typedef logic [TIME_W-1:0] time_type;
   typedef logic [ALU_W-1:0] alu_word_type;
   typedef logic [3:0] status_type;

   localparam count_type FULL_COUNT = count_type'(MAX_ENTRIES);

   localparam logic [1:0] REQ_ADD = 2'd0;
   localparam logic [1:0] REQ_POLL = 2'd1;
   localparam logic [1:0] REQ_OUTCOME = 2'd2;

   localparam logic [1:0] CSR_SUCCESS_PERIOD = 2'd0;
   localparam logic [1:0] CSR_FAILURE_PERIOD = 2'd1;
   localparam logic [1:0] CSR_MAX_ATTEMPTS = 2'd2;

   localparam logic [PERIOD_W-1:0] SUCCESS_PERIOD_RESET = 17'd1200;
   localparam logic [PERIOD_W-1:0] FAILURE_PERIOD_RESET = 17'd300;
   localparam logic [ATT_W-1:0] MAX_ATTEMPTS_RESET = 3'd3;

   localparam status_type ST_ADDED = 4'd0;
   localparam status_type ST_DUP = 4'd1;
   localparam status_type ST_FULL = 4'd2;
   localparam status_type ST_EMPTY = 4'd3;
   localparam status_type ST_NOTDUE = 4'd4;
   localparam status_type ST_DUE = 4'd5;
   localparam status_type ST_RETRY = 4'd6;
   localparam status_type ST_SUCC = 4'd7;
   localparam status_type ST_FAIL = 4'd8;

endpackage

/* rtl/rsch_alu.sv */
module rsch_alu (
   input rsch_pkg::alu_word_type op_a,
   input rsch_pkg::alu_word_type op_b,
   input logic sub,
   output rsch_pkg::alu_word_type sum
);

   assign sum = op_a + (sub ? ~op_b : op_b) + rsch_pkg::alu_word_type'(sub);

endmodule

/* rtl/reannounce_scheduler_core.sv */
// Add: duplicate scan, then order list shift. Empty list: poll and outcome answer from idle.
// Poll: head, slot and entry reads, then compare, add, subtract; a head never attempted
// stops at compare. Outcome: same reads, then order list rotation; a retry stops before it.
// One request at a time; busy stays high until the result strobe (empty list: never high),
// one read and one write port per array. Each result is shown for one cycle on rsp_strobe
// and cannot be stalled. Sync reset empties list, resets counters and CSRs; memories keep data.
module reannounce_scheduler_core (
   input logic clock,
   input logic reset,
   input logic start,
   output logic busy,
   input logic [1:0] req_type,
   input logic [31:0] req_key_id,
   input logic [31:0] req_now,
   input logic req_success,
   output logic rsp_strobe,
   output logic [3:0] rsp_status,
   output logic [31:0] rsp_issued_key,
   output logic [31:0] rsp_delay_seconds,
   input logic csr_valid,
   output logic csr_ready,
   input logic [1:0] csr_index,
   input logic [16:0] csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_SHIFT, S_HEAD, S_SLOT, S_ENTRY, S_CMP, S_ADD, S_SUB, S_OUTC, S_ROT
   } state_type;

   state_type state_ff, state_in;
   rsch_pkg::count_type count_ff, count_in, fresh_ff, fresh_in, ptr_ff, ptr_in;
   rsch_pkg::count_type pos_ff, pos_in, ptr_inc, ptr_dec, count_dec;
   logic [rsch_pkg::ATT_W-1:0] attempt_ff, attempt_in, max_ff, max_in;
   logic [rsch_pkg::ATT_W:0] att_next;
   logic [rsch_pkg::PERIOD_W-1:0] sp_ff, sp_in, fp_ff, fp_in;
   logic [1:0] type_ff, type_in;
   logic [rsch_pkg::KEY_W-1:0] key_ff, key_in;
   rsch_pkg::time_type now_ff, now_in;
   logic ok_ff, ok_in, pend_ff, pend_in, use_ff, use_in;
   rsch_pkg::slot_type pw_addr_ff, pw_addr_in, slot_ff, slot_in;
   logic [rsch_pkg::TIME_W:0] deadline_ff, deadline_in;
   logic rsp_strobe_ff, rsp_strobe_in;
   rsch_pkg::status_type rsp_status_ff, rsp_status_in;
   logic [31:0] rsp_key_ff, rsp_key_in, rsp_delay_ff, rsp_delay_in;

   logic [rsch_pkg::KEY_W-1:0] key_mem [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::time_type stime_mem [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::time_type ftime_mem [rsch_pkg::MAX_ENTRIES];
   logic sval_mem [rsch_pkg::MAX_ENTRIES];
   logic fval_mem [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::slot_type order_mem [rsch_pkg::MAX_ENTRIES];

   logic [rsch_pkg::KEY_W-1:0] key_rd_ff;
   rsch_pkg::time_type stime_rd_ff, ftime_rd_ff;
   logic sval_rd_ff, fval_rd_ff;
   rsch_pkg::slot_type order_rd_ff;

   rsch_pkg::slot_type order_raddr, order_waddr, order_wdata, ent_raddr;
   rsch_pkg::slot_type sval_waddr, fval_waddr;
   logic order_we, key_we, stime_we, ftime_we, sval_we, fval_we, sval_wdata, fval_wdata;
   rsch_pkg::alu_word_type alu_a, alu_b, alu_sum;
   logic alu_sub;

   rsch_alu u_alu (
      .op_a(alu_a),
      .op_b(alu_b),
      .sub(alu_sub),
      .sum(alu_sum)
   );

   assign busy = (state_ff != S_IDLE);
   assign csr_ready = ~busy;
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_issued_key = rsp_key_ff;
   assign rsp_delay_seconds = rsp_delay_ff;

   assign ptr_inc = ptr_ff + 1'b1;
   assign ptr_dec = ptr_ff - 1'b1;
   assign count_dec = count_ff - 1'b1;
   assign att_next = {1'b0, attempt_ff} + 1'b1;

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      fresh_in = fresh_ff;
      ptr_in = ptr_ff;
      pos_in = pos_ff;
      attempt_in = attempt_ff;
      max_in = max_ff;
      sp_in = sp_ff;
      fp_in = fp_ff;
      type_in = type_ff;
      key_in = key_ff;
      now_in = now_ff;
      ok_in = ok_ff;
      pend_in = pend_ff;
      use_in = use_ff;
      pw_addr_in = pw_addr_ff;
      slot_in = slot_ff;
      deadline_in = deadline_ff;
      rsp_strobe_in = 1'b0;
      rsp_status_in = rsp_status_ff;
      rsp_key_in = rsp_key_ff;
      rsp_delay_in = rsp_delay_ff;
      order_raddr = '0;
      order_we = 1'b0;
      order_waddr = pw_addr_ff;
      order_wdata = order_rd_ff;
      ent_raddr = slot_ff;
      key_we = 1'b0;
      stime_we = 1'b0;
      ftime_we = 1'b0;
      sval_we = 1'b0;
      sval_waddr = slot_ff;
      sval_wdata = 1'b0;
      fval_we = 1'b0;
      fval_waddr = slot_ff;
      fval_wdata = 1'b0;
      alu_a = '0;
      alu_b = '0;
      alu_sub = 1'b0;

      if (csr_valid && csr_ready) begin
         if (csr_index == rsch_pkg::CSR_SUCCESS_PERIOD) begin
            sp_in = csr_data;
         end else if (csr_index == rsch_pkg::CSR_FAILURE_PERIOD) begin
            fp_in = csr_data;
         end else if (csr_index == rsch_pkg::CSR_MAX_ATTEMPTS) begin
            max_in = csr_data[rsch_pkg::ATT_W-1:0];
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               type_in = req_type;
               key_in = req_key_id;
               now_in = req_now;
               ok_in = req_success;
               ptr_in = '0;
               pend_in = 1'b0;
               if (req_type == rsch_pkg::REQ_ADD) begin
                  state_in = S_SEARCH;
               end else if (req_type == rsch_pkg::REQ_POLL ||
                            req_type == rsch_pkg::REQ_OUTCOME) begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_status_in = rsch_pkg::ST_EMPTY;
                     rsp_key_in = '0;
                     rsp_delay_in = '0;
                  end else begin
                     state_in = S_HEAD;
                  end
               end
            end
         end
         S_SEARCH: begin
            ent_raddr = ptr_ff[rsch_pkg::IDX_W-1:0];
            if (pend_ff && key_rd_ff == key_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = rsch_pkg::ST_DUP;
               rsp_key_in = '0;
               rsp_delay_in = '0;
               state_in = S_IDLE;
            end else if (ptr_ff == count_ff) begin
               if (count_ff == rsch_pkg::FULL_COUNT) begin
                  rsp_strobe_in = 1'b1;
                  rsp_status_in = rsch_pkg::ST_FULL;
                  rsp_key_in = '0;
                  rsp_delay_in = '0;
                  state_in = S_IDLE;
               end else begin
                  key_we = 1'b1;
                  sval_we = 1'b1;
                  sval_waddr = count_ff[rsch_pkg::IDX_W-1:0];
                  fval_we = 1'b1;
                  fval_waddr = count_ff[rsch_pkg::IDX_W-1:0];
                  pos_in = (fresh_ff < count_ff) ? fresh_ff : count_ff;
                  pend_in = 1'b0;
                  state_in = S_SHIFT;
               end
            end else begin
               ptr_in = ptr_inc;
               pend_in = 1'b1;
            end
         end
         S_SHIFT: begin
            if (pend_ff) begin
               order_we = 1'b1;
            end
            if (ptr_ff > pos_ff) begin
               order_raddr = ptr_dec[rsch_pkg::IDX_W-1:0];
               pend_in = 1'b1;
               pw_addr_in = ptr_ff[rsch_pkg::IDX_W-1:0];
               ptr_in = ptr_dec;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               order_we = 1'b1;
               order_waddr = pos_ff[rsch_pkg::IDX_W-1:0];
               order_wdata = count_ff[rsch_pkg::IDX_W-1:0];
               count_in = count_ff + 1'b1;
               fresh_in = pos_ff + 1'b1;
               rsp_strobe_in = 1'b1;
               rsp_status_in = rsch_pkg::ST_ADDED;
               rsp_key_in = '0;
               rsp_delay_in = '0;
               state_in = S_IDLE;
            end
         end
         S_HEAD: begin
            order_raddr = '0;
            state_in = S_SLOT;
         end
         S_SLOT: begin
            slot_in = order_rd_ff;
            state_in = S_ENTRY;
         end
         S_ENTRY: begin
            state_in = (type_ff == rsch_pkg::REQ_POLL) ? S_CMP : S_OUTC;
         end
         S_CMP: begin
            alu_a = rsch_pkg::alu_word_type'(stime_rd_ff);
            alu_b = rsch_pkg::alu_word_type'(ftime_rd_ff);
            alu_sub = 1'b1;
            if (!sval_rd_ff && !fval_rd_ff) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = rsch_pkg::ST_DUE;
               rsp_key_in = key_rd_ff;
               rsp_delay_in = '0;
               state_in = S_IDLE;
            end else begin
               if (!fval_rd_ff) begin
                  use_in = 1'b1;
               end else if (!sval_rd_ff) begin
                  use_in = 1'b0;
               end else begin
                  use_in = ~alu_sum[rsch_pkg::ALU_W-1];
               end
               state_in = S_ADD;
            end
         end
         S_ADD: begin
            alu_a = rsch_pkg::alu_word_type'(use_ff ? stime_rd_ff : ftime_rd_ff);
            alu_b = rsch_pkg::alu_word_type'(use_ff ? sp_ff : fp_ff);
            deadline_in = alu_sum[rsch_pkg::TIME_W:0];
            state_in = S_SUB;
         end
         S_SUB: begin
            alu_a = rsch_pkg::alu_word_type'(deadline_ff);
            alu_b = rsch_pkg::alu_word_type'(now_ff);
            alu_sub = 1'b1;
            rsp_strobe_in = 1'b1;
            state_in = S_IDLE;
            if (alu_sum[rsch_pkg::ALU_W-1] || alu_sum == '0) begin
               rsp_status_in = rsch_pkg::ST_DUE;
               rsp_key_in = key_rd_ff;
               rsp_delay_in = '0;
            end else begin
               rsp_status_in = rsch_pkg::ST_NOTDUE;
               rsp_key_in = '0;
               rsp_delay_in = alu_sum[rsch_pkg::TIME_W] ? '1 : alu_sum[rsch_pkg::TIME_W-1:0];
            end
         end
         S_OUTC: begin
            if (!ok_ff && att_next < {1'b0, max_ff}) begin
               rsp_strobe_in = 1'b1;
               rsp_status_in = rsch_pkg::ST_RETRY;
               rsp_key_in = key_rd_ff;
               rsp_delay_in = rsch_pkg::time_type'(att_next);
               attempt_in = att_next[rsch_pkg::ATT_W-1:0];
               state_in = S_IDLE;
            end else begin
               if (ok_ff) begin
                  stime_we = 1'b1;
                  sval_we = 1'b1;
                  sval_wdata = 1'b1;
                  fval_we = 1'b1;
                  fval_wdata = 1'b0;
               end else begin
                  ftime_we = 1'b1;
                  fval_we = 1'b1;
                  fval_wdata = 1'b1;
               end
               attempt_in = '0;
               if (fresh_ff != '0) begin
                  fresh_in = fresh_ff - 1'b1;
               end
               ptr_in = '0;
               pend_in = 1'b0;
               state_in = S_ROT;
            end
         end
         S_ROT: begin
            if (pend_ff) begin
               order_we = 1'b1;
            end
            if (ptr_inc < count_ff) begin
               order_raddr = ptr_inc[rsch_pkg::IDX_W-1:0];
               pend_in = 1'b1;
               pw_addr_in = ptr_ff[rsch_pkg::IDX_W-1:0];
               ptr_in = ptr_inc;
            end else if (pend_ff) begin
               pend_in = 1'b0;
            end else begin
               order_we = 1'b1;
               order_waddr = count_dec[rsch_pkg::IDX_W-1:0];
               order_wdata = slot_ff;
               rsp_strobe_in = 1'b1;
               rsp_status_in = ok_ff ? rsch_pkg::ST_SUCC : rsch_pkg::ST_FAIL;
               rsp_key_in = key_rd_ff;
               rsp_delay_in = '0;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         fresh_ff <= '0;
         attempt_ff <= '0;
         sp_ff <= rsch_pkg::SUCCESS_PERIOD_RESET;
         fp_ff <= rsch_pkg::FAILURE_PERIOD_RESET;
         max_ff <= rsch_pkg::MAX_ATTEMPTS_RESET;
         pend_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         fresh_ff <= fresh_in;
         attempt_ff <= attempt_in;
         sp_ff <= sp_in;
         fp_ff <= fp_in;
         max_ff <= max_in;
         pend_ff <= pend_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      ptr_ff <= ptr_in;
      pos_ff <= pos_in;
      type_ff <= type_in;
      key_ff <= key_in;
      now_ff <= now_in;
      ok_ff <= ok_in;
      use_ff <= use_in;
      pw_addr_ff <= pw_addr_in;
      slot_ff <= slot_in;
      deadline_ff <= deadline_in;
      rsp_status_ff <= rsp_status_in;
      rsp_key_ff <= rsp_key_in;
      rsp_delay_ff <= rsp_delay_in;
   end

   always_ff @(posedge clock) begin
      if (order_we) begin
         order_mem[order_waddr] <= order_wdata;
      end
      order_rd_ff <= order_mem[order_raddr];
   end

   always_ff @(posedge clock) begin
      if (key_we) begin
         key_mem[count_ff[rsch_pkg::IDX_W-1:0]] <= key_ff;
      end
      key_rd_ff <= key_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (stime_we) begin
         stime_mem[slot_ff] <= now_ff;
      end
      stime_rd_ff <= stime_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (ftime_we) begin
         ftime_mem[slot_ff] <= now_ff;
      end
      ftime_rd_ff <= ftime_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (sval_we) begin
         sval_mem[sval_waddr] <= sval_wdata;
      end
      sval_rd_ff <= sval_mem[ent_raddr];
   end

   always_ff @(posedge clock) begin
      if (fval_we) begin
         fval_mem[fval_waddr] <= fval_wdata;
      end
      fval_rd_ff <= fval_mem[ent_raddr];
   end

endmodule

/* rtl/rsch_checker.sv */
module rsch_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic rsp_strobe,
   input logic [3:0] rsp_status,
   input logic [31:0] rsp_issued_key,
   input logic [31:0] rsp_delay_seconds
);

   a_status_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_status <= rsch_pkg::ST_FAIL)
      else $error("result status out of range");

   a_list_results_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && (rsp_status == rsch_pkg::ST_ADDED || rsp_status == rsch_pkg::ST_DUP ||
                     rsp_status == rsch_pkg::ST_FULL || rsp_status == rsch_pkg::ST_EMPTY)
      |-> rsp_issued_key == '0 && rsp_delay_seconds == '0)
      else $error("list result carries key or delay");

   a_notdue_wait: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == rsch_pkg::ST_NOTDUE
      |-> rsp_delay_seconds != '0 && rsp_issued_key == '0)
      else $error("not-due result without a wait");

   a_retry_delay: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == rsch_pkg::ST_RETRY
      |-> rsp_delay_seconds >= 32'd1 && rsp_delay_seconds <= 32'd6)
      else $error("retry delay out of range");

   a_result_follows_request: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy) || $past(start))
      else $error("result without a request");

endmodule

bind reannounce_scheduler_core rsch_checker u_rsch_checker (.*);

/* dv/reannounce_scheduler_core_test.sv */
`timescale 1ns / 1ps

module reannounce_scheduler_core_test;

   localparam logic [1:0] REQ_UNKNOWN = 2'd3;

   typedef struct packed {
      rsch_pkg::status_type status;
      logic [rsch_pkg::KEY_W-1:0] issued_key;
      logic [31:0] delay_seconds;
   } answer_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_type = rsch_pkg::REQ_ADD;
   logic [31:0] req_key_id = '0;
   logic [31:0] req_now = '0;
   logic req_success = 1'b0;
   logic rsp_strobe;
   logic [3:0] rsp_status;
   logic [31:0] rsp_issued_key;
   logic [31:0] rsp_delay_seconds;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [1:0] csr_index = rsch_pkg::CSR_SUCCESS_PERIOD;
   logic [16:0] csr_data = '0;

   logic [rsch_pkg::KEY_W-1:0] entry_key [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::time_type entry_succ_time [rsch_pkg::MAX_ENTRIES];
   logic entry_succ_seen [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::time_type entry_fail_time [rsch_pkg::MAX_ENTRIES];
   logic entry_fail_seen [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::slot_type rotation [rsch_pkg::MAX_ENTRIES];
   rsch_pkg::count_type stored_count = '0;
   rsch_pkg::count_type unattempted = '0;
   logic [rsch_pkg::ATT_W-1:0] failed_tries = '0;
   logic [rsch_pkg::PERIOD_W-1:0] succ_period = rsch_pkg::SUCCESS_PERIOD_RESET;
   logic [rsch_pkg::PERIOD_W-1:0] fail_period = rsch_pkg::FAILURE_PERIOD_RESET;
   logic [rsch_pkg::ATT_W-1:0] attempt_limit = rsch_pkg::MAX_ATTEMPTS_RESET;

   answer_type pending_answers [$];
   logic [rsch_pkg::KEY_W-1:0] key_pool [32];
   rsch_pkg::time_type clock_now = '0;
   bit gaps_on = 1'b1;
   int error_count = 0;

   reannounce_scheduler_core i_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_key_id(req_key_id),
      .req_now(req_now),
      .req_success(req_success),
      .rsp_strobe(rsp_strobe),
      .rsp_status(rsp_status),
      .rsp_issued_key(rsp_issued_key),
      .rsp_delay_seconds(rsp_delay_seconds),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #6 clock = ~clock;

   function automatic bit apply_request(input logic [1:0] kind,
         input logic [rsch_pkg::KEY_W-1:0] key, input rsch_pkg::time_type now, input logic ok,
         output answer_type ans);
      rsch_pkg::slot_type slot;
      logic [rsch_pkg::TIME_W:0] deadline;
      logic [rsch_pkg::TIME_W:0] wait_left;
      logic by_success;
      ans = '0;
      case (kind)
         rsch_pkg::REQ_ADD: begin
            for (int i = 0; i < int'(stored_count); i++) begin
               if (entry_key[i] == key) begin
                  ans.status = rsch_pkg::ST_DUP;
                  return 1'b1;
               end
            end
            if (stored_count >= rsch_pkg::FULL_COUNT) begin
               ans.status = rsch_pkg::ST_FULL;
               return 1'b1;
            end
            slot = rsch_pkg::slot_type'(stored_count);
            entry_key[slot] = key;
            entry_succ_time[slot] = '0;
            entry_fail_time[slot] = '0;
            entry_succ_seen[slot] = 1'b0;
            entry_fail_seen[slot] = 1'b0;
            for (int i = int'(stored_count); i > int'(unattempted); i--) begin
               rotation[i] = rotation[i - 1];
            end
            rotation[rsch_pkg::slot_type'(unattempted)] = slot;
            unattempted = unattempted + 1'b1;
            stored_count = stored_count + 1'b1;
            ans.status = rsch_pkg::ST_ADDED;
            return 1'b1;
         end
         rsch_pkg::REQ_POLL: begin
            if (stored_count == 0) begin
               ans.status = rsch_pkg::ST_EMPTY;
               return 1'b1;
            end
            slot = rotation[0];
            if (!entry_succ_seen[slot] && !entry_fail_seen[slot]) begin
               ans.status = rsch_pkg::ST_DUE;
               ans.issued_key = entry_key[slot];
               return 1'b1;
            end
            if (!entry_fail_seen[slot]) begin
               by_success = 1'b1;
            end else if (!entry_succ_seen[slot]) begin
               by_success = 1'b0;
            end else begin
               by_success = entry_succ_time[slot] >= entry_fail_time[slot];
            end
            if (by_success) begin
               deadline = {1'b0, entry_succ_time[slot]} + succ_period;
            end else begin
               deadline = {1'b0, entry_fail_time[slot]} + fail_period;
            end
            if (deadline <= {1'b0, now}) begin
               ans.status = rsch_pkg::ST_DUE;
               ans.issued_key = entry_key[slot];
            end else begin
               wait_left = deadline - {1'b0, now};
               ans.status = rsch_pkg::ST_NOTDUE;
               ans.delay_seconds = wait_left[rsch_pkg::TIME_W] ? '1 :
                  wait_left[rsch_pkg::TIME_W-1:0];
            end
            return 1'b1;
         end
         rsch_pkg::REQ_OUTCOME: begin
            if (stored_count == 0) begin
               ans.status = rsch_pkg::ST_EMPTY;
               return 1'b1;
            end
            slot = rotation[0];
            if (!ok && ({1'b0, failed_tries} + 4'd1 < {1'b0, attempt_limit})) begin
               ans.status = rsch_pkg::ST_RETRY;
               ans.issued_key = entry_key[slot];
               ans.delay_seconds = {29'd0, failed_tries} + 32'd1;
               failed_tries = failed_tries + 1'b1;
               return 1'b1;
            end
            if (ok) begin
               entry_succ_time[slot] = now;
               entry_succ_seen[slot] = 1'b1;
               entry_fail_time[slot] = '0;
               entry_fail_seen[slot] = 1'b0;
            end else begin
               entry_fail_time[slot] = now;
               entry_fail_seen[slot] = 1'b1;
            end
            failed_tries = '0;
            if (unattempted != 0) unattempted = unattempted - 1'b1;
            for (int i = 0; i + 1 < int'(stored_count); i++) begin
               rotation[i] = rotation[i + 1];
            end
            rotation[rsch_pkg::slot_type'(stored_count - 1'b1)] = slot;
            ans.status = ok ? rsch_pkg::ST_SUCC : rsch_pkg::ST_FAIL;
            ans.issued_key = entry_key[slot];
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic rsch_pkg::time_type next_now();
      int r;
      r = $urandom_range(99);
      if (r < 40) begin
         clock_now = clock_now + $urandom_range(3);
      end else if (r < 75) begin
         clock_now = clock_now + $urandom_range(int'(fail_period));
      end else if (r < 90) begin
         clock_now = clock_now + $urandom_range(int'(succ_period) + int'(fail_period));
      end else if (r < 96) begin
         clock_now = $urandom;
      end else begin
         return ($urandom_range(1) != 0) ? {rsch_pkg::TIME_W{1'b1}} :
            {rsch_pkg::TIME_W{1'b0}};
      end
      return clock_now;
   endfunction

   task automatic report_mismatch(input string what);
      error_count++;
      $display("MISMATCH at %0t ns: %s", $time, what);
   endtask

   task automatic send_request(input logic [1:0] kind, input logic [rsch_pkg::KEY_W-1:0] key,
         input rsch_pkg::time_type now, input logic ok);
      answer_type ans;
      while (gaps_on && $urandom_range(99) < 37) begin
         @(negedge clock);
         start <= 1'b0;
      end
      @(negedge clock);
      start <= 1'b1;
      req_type <= kind;
      req_key_id <= key;
      req_now <= now;
      req_success <= ok;
      @(posedge clock);
      while (busy) @(posedge clock);
      if (apply_request(kind, key, now, ok, ans)) begin
         pending_answers.insert(pending_answers.size(), ans);
      end
   endtask

   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index,
         input logic [rsch_pkg::PERIOD_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (index)
         rsch_pkg::CSR_SUCCESS_PERIOD: succ_period = value;
         rsch_pkg::CSR_FAILURE_PERIOD: fail_period = value;
         rsch_pkg::CSR_MAX_ATTEMPTS: attempt_limit = value[rsch_pkg::ATT_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic configure(input int succ_value, input int fail_value, input int limit_value);
      drain_results();
      write_register(rsch_pkg::CSR_SUCCESS_PERIOD, rsch_pkg::PERIOD_W'(succ_value));
      write_register(rsch_pkg::CSR_FAILURE_PERIOD, rsch_pkg::PERIOD_W'(fail_value));
      write_register(rsch_pkg::CSR_MAX_ATTEMPTS, rsch_pkg::PERIOD_W'(limit_value));
   endtask

   task automatic test_empty_list();
      send_request(rsch_pkg::REQ_POLL, $urandom, '0, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, '1, 1'b1);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd5, 1'b0);
      send_request(REQ_UNKNOWN, '1, '1, 1'b1);
   endtask

   task automatic test_success_window();
      send_request(rsch_pkg::REQ_ADD, '0, $urandom, 1'b0);
      send_request(rsch_pkg::REQ_ADD, '0, $urandom, 1'b1);
      send_request(rsch_pkg::REQ_POLL, $urandom, '0, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, '1, 1'b1);
      send_request(rsch_pkg::REQ_POLL, $urandom, '0, 1'b1);
      send_request(rsch_pkg::REQ_POLL, $urandom, '1, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd100, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd100, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd100, 1'b0);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd5, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd10, 1'b1);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd1209, 1'b0);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd1210, 1'b0);
   endtask

   task automatic test_failure_window();
      configure(86400, 1, 1);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd50, 1'b0);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd50, 1'b0);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd51, 1'b0);
   endtask

   task automatic test_head_replacement();
      configure(1, 1, 7);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd60, 1'b0);
      send_request(rsch_pkg::REQ_ADD, '1, $urandom, 1'b0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd61, 1'b0);
      send_request(rsch_pkg::REQ_POLL, $urandom, 32'd61, 1'b1);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd62, 1'b1);
      configure(1, 1, 0);
      send_request(rsch_pkg::REQ_OUTCOME, $urandom, 32'd63, 1'b0);
   endtask

   task automatic run_random_phase(input int count);
      int done;
      int r;
      logic [1:0] kind;
      logic [rsch_pkg::KEY_W-1:0] key;
      done = 0;
      while (done < count) begin
         r = $urandom_range(99);
         if (r < 15) kind = rsch_pkg::REQ_ADD;
         else if (r < 50) kind = rsch_pkg::REQ_POLL;
         else if (r < 95) kind = rsch_pkg::REQ_OUTCOME;
         else kind = REQ_UNKNOWN;
         key = ($urandom_range(99) < 70) ? key_pool[$urandom_range(31)] : $urandom;
         send_request(kind, key, next_now(), $urandom_range(99) < 55);
         if (kind != REQ_UNKNOWN) done++;
      end
   endtask

   task automatic test_random_traffic();
      configure(1200, 300, 3);
      run_random_phase(100);
      configure(1, 1, 1);
      run_random_phase(100);
      gaps_on = 1'b0;
      configure(86400, 86400, 7);
      run_random_phase(100);
      gaps_on = 1'b1;
      configure(1, 86400, 0);
      run_random_phase(100);
      configure(86400, 1, 2);
      run_random_phase(100);
      configure($urandom_range(1, 86400), $urandom_range(1, 86400), $urandom_range(0, 7));
      run_random_phase(100);
   endtask

   task automatic test_fill_to_capacity();
      configure($urandom_range(1, 600), $urandom_range(1, 600), $urandom_range(1, 7));
      while (stored_count < rsch_pkg::FULL_COUNT) begin
         send_request(rsch_pkg::REQ_ADD, $urandom, $urandom, 1'($urandom_range(1)));
      end
      send_request(rsch_pkg::REQ_ADD, $urandom, $urandom, 1'b0);
      send_request(rsch_pkg::REQ_ADD, entry_key[0], $urandom, 1'b1);
      run_random_phase(20);
   endtask

   always @(posedge clock) begin : check_answers
      answer_type want;
      if (!reset && rsp_strobe) begin
         if (pending_answers.size() == 0) begin
            report_mismatch($sformatf("unexpected result: status %0d key %h delay %0d",
               rsp_status, rsp_issued_key, rsp_delay_seconds));
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_issued_key !== want.issued_key ||
                  rsp_delay_seconds !== want.delay_seconds) begin
               report_mismatch($sformatf(
                  "got status %0d key %h delay %0d, expected status %0d key %h delay %0d",
                  rsp_status, rsp_issued_key, rsp_delay_seconds,
                  want.status, want.issued_key, want.delay_seconds));
            end
         end
      end
   end

   initial begin
      for (int i = 0; i < 32; i++) key_pool[i] = $urandom;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_empty_list();
      test_success_window();
      test_failure_window();
      test_head_replacement();
      test_random_traffic();
      test_fill_to_capacity();
      drain_results();
      if (error_count == 0) begin
         $display("reannounce_scheduler_core_test: clean");
      end else begin
         $display("reannounce_scheduler_core_test: errors");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("reannounce_scheduler_core_test: errors");
      $finish;
   end

endmodule
